@@ sv/qnc_pkg.sv @@
// ----------------------------------------------------------------------------
// qnc_pkg - shared types and tables for the quadtree neighbor code block
// Query and result structs, search opcodes, direction codes and the
// per-quadrant lookup tables used by the digit sequencer.
// ----------------------------------------------------------------------------
package qnc_pkg;

	localparam int QNC_MAX_DEPTH   = 16;
	localparam int QNC_CODE_DIGITS = 16;
	localparam int QNC_DEPTH_LIM   =
		(QNC_MAX_DEPTH < QNC_CODE_DIGITS) ? QNC_MAX_DEPTH : QNC_CODE_DIGITS;

	typedef enum logic {
		QNC_OP_EDGE   = 1'b0,
		QNC_OP_CORNER = 1'b1
	} qnc_op_t;

	// edge directions
	typedef enum logic [1:0] {
		QNC_DIR_N = 2'd0,
		QNC_DIR_W = 2'd1,
		QNC_DIR_E = 2'd2,
		QNC_DIR_S = 2'd3
	} qnc_edge_dir_t;

	// corner directions
	typedef enum logic [1:0] {
		QNC_CDIR_NW = 2'd0,
		QNC_CDIR_NE = 2'd1,
		QNC_CDIR_SW = 2'd2,
		QNC_CDIR_SE = 2'd3
	} qnc_corner_dir_t;

	// quadrant digits: bit 1 south, bit 0 east
	typedef enum logic [1:0] {
		QNC_Q_NW = 2'd0,
		QNC_Q_NE = 2'd1,
		QNC_Q_SW = 2'd2,
		QNC_Q_SE = 2'd3
	} qnc_quad_t;

	// corner step outcome: hand off to edge search in a direction, climb, or stop
	typedef enum logic [2:0] {
		QNC_STEP_N    = 3'd0,
		QNC_STEP_W    = 3'd1,
		QNC_STEP_E    = 3'd2,
		QNC_STEP_S    = 3'd3,
		QNC_STEP_UP   = 3'd4,
		QNC_STEP_SAME = 3'd5
	} qnc_step_t;

	typedef enum logic {
		QNC_IDLE = 1'b0,
		QNC_RUN  = 1'b1
	} qnc_state_t;

	typedef struct packed {
		logic        op;
		logic [1:0]  direction;
		logic [4:0]  depth;
		logic [31:0] quad_code;
	} qnc_query_t;

	typedef struct packed {
		logic        found;
		logic [31:0] nbr_code;
		logic [4:0]  levels_changed;
	} qnc_result_t;

	// mirrored digit across an edge
	function automatic logic [1:0] mirror_edge(input logic [1:0] q, input qnc_edge_dir_t dir);
		logic [1:0] m;
		unique case (dir)
			QNC_DIR_N, QNC_DIR_S: m = q ^ 2'b10;
			default:              m = q ^ 2'b01;
		endcase
		return m;
	endfunction

	// neighbor lies outside the parent, keep climbing
	function automatic logic climb_edge(input logic [1:0] q, input qnc_edge_dir_t dir);
		logic c;
		unique case (dir)
			QNC_DIR_N: c = ~q[1];
			QNC_DIR_W: c = ~q[0];
			QNC_DIR_E: c = q[0];
			QNC_DIR_S: c = q[1];
			default:   c = 1'b0;
		endcase
		return c;
	endfunction

	function automatic qnc_step_t corner_step(input logic [1:0] q, input logic [1:0] dir);
		qnc_step_t s;
		unique case ({q, dir})
			{QNC_Q_NW, QNC_CDIR_NW}: s = QNC_STEP_UP;
			{QNC_Q_NW, QNC_CDIR_NE}: s = QNC_STEP_N;
			{QNC_Q_NW, QNC_CDIR_SW}: s = QNC_STEP_W;
			{QNC_Q_NW, QNC_CDIR_SE}: s = QNC_STEP_SAME;
			{QNC_Q_NE, QNC_CDIR_NW}: s = QNC_STEP_N;
			{QNC_Q_NE, QNC_CDIR_NE}: s = QNC_STEP_UP;
			{QNC_Q_NE, QNC_CDIR_SW}: s = QNC_STEP_SAME;
			{QNC_Q_NE, QNC_CDIR_SE}: s = QNC_STEP_E;
			{QNC_Q_SW, QNC_CDIR_NW}: s = QNC_STEP_W;
			{QNC_Q_SW, QNC_CDIR_NE}: s = QNC_STEP_SAME;
			{QNC_Q_SW, QNC_CDIR_SW}: s = QNC_STEP_UP;
			{QNC_Q_SW, QNC_CDIR_SE}: s = QNC_STEP_S;
			{QNC_Q_SE, QNC_CDIR_NW}: s = QNC_STEP_SAME;
			{QNC_Q_SE, QNC_CDIR_NE}: s = QNC_STEP_E;
			{QNC_Q_SE, QNC_CDIR_SW}: s = QNC_STEP_S;
			{QNC_Q_SE, QNC_CDIR_SE}: s = QNC_STEP_UP;
			default:                 s = QNC_STEP_UP;
		endcase
		return s;
	endfunction

endpackage

@@ sv/quadtree_neighbor_code.sv @@
// ----------------------------------------------------------------------------
// quadtree_neighbor_code - equal-size neighbor of a quadtree location code
// Edge and corner neighbor search, one quadrant digit per clock.
// ----------------------------------------------------------------------------
// A query is transferred when start is high and busy is low. The block then
// walks the code from the finest digit toward the root, one digit per clock
// through a single digit-rewrite unit: busy stays high until the neighbor is
// known, after rewriting between 1 and depth digits, or until the search runs
// past the root. The result shows on result for exactly one cycle with done
// high, in the first cycle in which busy is low; the receiver cannot stall it.
// Since busy is already low then, the next query may be transferred right
// away. Depths above 16 are clamped, and code bits above the effective depth
// are ignored.
module quadtree_neighbor_code (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  qnc_pkg::qnc_query_t  query,
	output logic                 busy,
	output logic                 done,
	output qnc_pkg::qnc_result_t result
);

	qnc_pkg::qnc_state_t    state_q, state_nxt;
	qnc_pkg::qnc_op_t       mode_q;        // edge or corner search in progress
	logic [1:0]             dir_q;         // edge or corner direction
	logic [4:0]             idx_q;         // digits left to visit
	logic [4:0]             cnt_q;         // digits rewritten so far, inclusive
	logic [4:0]             depth_q;       // effective depth
	logic [31:0]            code_q;        // working code, finished digits rewritten
	logic                   done_q;
	qnc_pkg::qnc_result_t   result_q;

	// load-side decode
	logic [4:0]             depth_eff;
	logic [31:0]            load_mask;
	logic                   accept;

	// digit unit
	logic [3:0]             dig_idx;
	logic [1:0]             cur_q;
	logic [1:0]             new_digit;
	qnc_pkg::qnc_step_t     cstep;
	logic                   stop_found;    // neighbor settled
	logic                   stop_miss;     // ran past the root
	logic                   hand_off;      // corner turns into edge search
	logic [31:0]            code_nxt;

	assign accept = start && (state_q == qnc_pkg::QNC_IDLE);

	always_comb begin
		if (query.depth > 5'(qnc_pkg::QNC_DEPTH_LIM))
			depth_eff = 5'(qnc_pkg::QNC_DEPTH_LIM);
		else
			depth_eff = query.depth;
		for (int i = 0; i < qnc_pkg::QNC_CODE_DIGITS; i++) begin
			load_mask[2*i +: 2] = (5'(i) < depth_eff) ? 2'b11 : 2'b00;
		end
	end

	// one digit per cycle: read the finest unvisited digit and rewrite it
	always_comb begin
		dig_idx    = 4'(idx_q - 5'd1);
		cur_q      = code_q[{dig_idx, 1'b0} +: 2];
		cstep      = qnc_pkg::corner_step(cur_q, dir_q);
		new_digit  = cur_q;
		stop_found = 1'b0;
		stop_miss  = 1'b0;
		hand_off   = 1'b0;
		if (idx_q == 5'd0) begin
			stop_miss = 1'b1;
		end else if (mode_q == qnc_pkg::QNC_OP_EDGE) begin
			new_digit  = qnc_pkg::mirror_edge(cur_q, qnc_pkg::qnc_edge_dir_t'(dir_q));
			stop_found = ~qnc_pkg::climb_edge(cur_q, qnc_pkg::qnc_edge_dir_t'(dir_q));
		end else begin
			new_digit = cur_q ^ 2'b11;   // diagonal flip
			case (cstep)
				qnc_pkg::QNC_STEP_SAME: stop_found = 1'b1;
				qnc_pkg::QNC_STEP_UP:   hand_off = 1'b0;
				default:                hand_off = 1'b1;
			endcase
		end
		code_nxt = code_q;
		code_nxt[{dig_idx, 1'b0} +: 2] = new_digit;
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			qnc_pkg::QNC_IDLE: begin
				if (start)
					state_nxt = qnc_pkg::QNC_RUN;
			end
			qnc_pkg::QNC_RUN: begin
				if (stop_found || stop_miss)
					state_nxt = qnc_pkg::QNC_IDLE;
			end
			default: state_nxt = qnc_pkg::QNC_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		busy   = (state_q == qnc_pkg::QNC_RUN);
		done   = done_q;
		result = result_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= qnc_pkg::QNC_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_nxt;
			done_q  <= (state_q == qnc_pkg::QNC_RUN) && (stop_found || stop_miss);
		end
	end

	// datapath, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q  <= qnc_pkg::qnc_op_t'(query.op);
			dir_q   <= query.direction;
			idx_q   <= depth_eff;
			depth_q <= depth_eff;
			cnt_q   <= 5'd1;
			code_q  <= query.quad_code & load_mask;
		end else if (state_q == qnc_pkg::QNC_RUN) begin
			if (stop_found) begin
				result_q.found          <= 1'b1;
				result_q.nbr_code       <= code_nxt;
				result_q.levels_changed <= cnt_q;
			end else if (stop_miss) begin
				result_q.found          <= 1'b0;
				result_q.nbr_code       <= '0;
				result_q.levels_changed <= '0;
			end else begin
				code_q <= code_nxt;
				idx_q  <= idx_q - 5'd1;
				cnt_q  <= cnt_q + 5'd1;
				if (hand_off) begin
					mode_q <= qnc_pkg::QNC_OP_EDGE;
					dir_q  <= cstep[1:0];
				end
			end
		end
	end

`ifndef SYNTHESIS
	a_done_after_run: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(state_q == qnc_pkg::QNC_RUN))
		else $error("result strobe without a finished search");

	a_miss_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && !result_q.found) |->
		(result_q.nbr_code == 32'd0 && result_q.levels_changed == 5'd0))
		else $error("missing neighbor carries nonzero fields");

	a_found_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && result_q.found) |->
		(result_q.levels_changed != 5'd0 && result_q.levels_changed <= depth_q))
		else $error("found neighbor with bad level count");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("transfer did not start a search");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == qnc_pkg::QNC_RUN) |-> (idx_q <= depth_q))
		else $error("digit index beyond depth");
`endif

endmodule
